>>> hdl/ppgbd_pkg.sv
// Shared constants and types for the PPG bandpass beat detector.
package ppgbd_pkg;

    localparam int INTERVAL_COUNT_DEF = 6;
    localparam int SAMPLE_BITS_DEF    = 18;

    localparam logic [22:0] SCALE_K = 23'd4816734;

    localparam logic signed [31:0] COEF_A0 = -32'sd46120535;
    localparam logic signed [31:0] COEF_A1 = 32'sd98962630;
    localparam logic signed [31:0] COEF_A2 = -32'sd314555991;
    localparam logic signed [31:0] COEF_A3 = 32'sd529838923;

    localparam logic [18:0] FIELD19_MAX = 19'h7FFFF;

    localparam logic       REG_OUTPUT_MODE    = 1'b0;
    localparam logic       REG_BEAT_THRESHOLD = 1'b1;

    localparam logic signed [16:0] THRESHOLD_RESET = -17'sd100;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_SCALE = 8'b0000_0010,
        ST_MAC   = 8'b0000_0100,
        ST_ROUND = 8'b0000_1000,
        ST_BEAT  = 8'b0001_0000,
        ST_SUM   = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

endpackage

>>> hdl/ppg_bandpass_beat_detector.sv
// Top level of the PPG bandpass filter and heart-beat detector.
//
//  channel   valid      ready      payload
//  in        in_valid   in_ready   command, sample_in
//  out       out_valid  out_ready  channel_out, value_out, beat_flag,
//                                  interval_sum, rate_tenths_bpm
//  cfg       cfg_valid  cfg_ready  cfg_index, cfg_data
//
// Each request is processed by a small sequencer around one shared 32x32
// signed multiplier and a 64-bit accumulator: it scales the sample, runs
// four multiply-accumulate steps for the feedback taps, rounds, tests for a
// beat, adds up the INTERVAL_COUNT intervals, runs a restoring divider for
// the rate (cut short when the sum is zero) and loads the output register.
// A new request is accepted only in the idle state, which the sequencer
// reaches again once the result of the previous request has been loaded.
// The next request is taken while the result waits in the output register;
// that request then holds the sequencer in its output state until the
// register is free. Reset clears all histories, the state, the configuration and the output valid flag at once.
module ppg_bandpass_beat_detector #(
    parameter int INTERVAL_COUNT = ppgbd_pkg::INTERVAL_COUNT_DEF,
    parameter int SAMPLE_BITS    = ppgbd_pkg::SAMPLE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               command,
    input  logic [SAMPLE_BITS-1:0] sample_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               channel_out,
    output logic signed [31:0] value_out,
    output logic               beat_flag,
    output logic [18:0]        interval_sum,
    output logic [18:0]        rate_tenths_bpm,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [16:0]        cfg_data
);

    localparam int IDX_W   = (INTERVAL_COUNT > 1) ? $clog2(INTERVAL_COUNT) : 1;
    localparam int SUM_W   = 16 + $clog2(INTERVAL_COUNT + 1);
    localparam int DIV_N   = 60000 * INTERVAL_COUNT;
    localparam int DIV_W   = $clog2(DIV_N + 1);
    localparam int DCNT_W  = $clog2(DIV_W + 1);

    ppgbd_pkg::state_t state_reg, state_next;

    // Filter histories, index 0 oldest. Channel selected by chan_reg.
    logic signed [31:0] xh_reg [2][5];
    logic signed [31:0] yh_reg [2][5];
    logic signed [31:0] prev_level_reg;
    logic [31:0]        count_reg;
    logic [31:0]        last_beat_reg;
    logic [15:0]        ivs_reg [INTERVAL_COUNT];
    logic [IDX_W-1:0]   widx_reg;
    logic               mode_reg;
    logic signed [16:0] thr_reg;

    logic               chan_reg;
    logic [SAMPLE_BITS-1:0] samp_reg;
    logic signed [31:0] xs_reg;
    logic signed [63:0] acc_reg;
    logic [2:0]         tap_reg;
    logic signed [31:0] neg_reg;
    logic               beat_reg;
    logic [IDX_W-1:0]   sidx_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [DIV_W-1:0]   quo_reg;
    logic [SUM_W:0]     rem_reg;
    logic [DCNT_W-1:0]  dcnt_reg;

    logic               ovalid_reg;
    logic               ochan_reg;
    logic signed [31:0] oval_reg;
    logic               obeat_reg;
    logic [18:0]        osum_reg;
    logic [18:0]        orate_reg;

    // Shared multiplier: operands chosen by the sequencer.
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;

    always_comb
    begin
        // The feedback taps read the history as it stands before the shift,
        // so tap k of the shifted history is entry k + 1 here.
        mul_a = yh_reg[chan_reg][{1'b0, tap_reg[1:0]} + 3'd1];
        mul_b = ppgbd_pkg::COEF_A0;
        case (tap_reg[1:0])
            2'd0: mul_b = ppgbd_pkg::COEF_A0;
            2'd1: mul_b = ppgbd_pkg::COEF_A1;
            2'd2: mul_b = ppgbd_pkg::COEF_A2;
            2'd3: mul_b = ppgbd_pkg::COEF_A3;
            default: mul_b = ppgbd_pkg::COEF_A0;
        endcase
        if (state_reg == ppgbd_pkg::ST_SCALE)
        begin
            mul_a = 32'(signed'({1'b0, samp_reg}));
            mul_b = 32'(signed'({1'b0, ppgbd_pkg::SCALE_K}));
        end
    end

    assign mul_p = mul_a * mul_b;

    // Rounding, saturation and negation of the filter output, and the beat, interval and divider terms.
    logic signed [63:0] rnd;
    logic signed [35:0] yq;
    logic signed [31:0] ysat, yneg;
    logic signed [63:0] fir_term;
    logic signed [33:0] thr_q;
    logic               beat_now;
    logic [31:0]        iv_full;
    logic [15:0]        iv_sat;
    logic [SUM_W:0]     rem_try;

    assign fir_term = 64'(signed'(34'(xh_reg[chan_reg][1]) + 34'(xs_reg)
                      - 34'(xh_reg[chan_reg][3]) * 34'sd2)) <<< 28;
    assign rnd      = acc_reg + 64'sd134217728;
    assign yq       = 36'(rnd >>> 28);
    assign ysat     = (yq > 36'sd2147483647) ? 32'sh7FFFFFFF :
                      (yq < -36'sd2147483648) ? 32'sh80000000 : yq[31:0];
    assign yneg     = (ysat == 32'sh80000000) ? 32'sh7FFFFFFF : -ysat;
    assign thr_q    = 34'(thr_reg) <<< 8;
    assign beat_now = !chan_reg && (34'(neg_reg) >= thr_q) && (34'(prev_level_reg) < thr_q);
    assign iv_full  = count_reg - last_beat_reg;
    assign iv_sat   = (iv_full > 32'd65535) ? 16'hFFFF : iv_full[15:0];
    assign rem_try  = {rem_reg[SUM_W-1:0], quo_reg[DIV_W-1]} - {1'b0, sum_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ppgbd_pkg::ST_IDLE:  if (in_valid) state_next = ppgbd_pkg::ST_SCALE;
            ppgbd_pkg::ST_SCALE: state_next = ppgbd_pkg::ST_MAC;
            ppgbd_pkg::ST_MAC:   if (tap_reg == 3'd3) state_next = ppgbd_pkg::ST_ROUND;
            ppgbd_pkg::ST_ROUND: state_next = ppgbd_pkg::ST_BEAT;
            ppgbd_pkg::ST_BEAT:  state_next = ppgbd_pkg::ST_SUM;
            ppgbd_pkg::ST_SUM:
                if (32'(sidx_reg) == INTERVAL_COUNT - 1) state_next = ppgbd_pkg::ST_DIV;
            ppgbd_pkg::ST_DIV:
                if (sum_reg == '0 || 32'(dcnt_reg) == DIV_W - 1) state_next = ppgbd_pkg::ST_OUT;
            ppgbd_pkg::ST_OUT:   if (!ovalid_reg) state_next = ppgbd_pkg::ST_IDLE;
            default:             state_next = ppgbd_pkg::ST_IDLE;
        endcase
    end

    assign in_ready  = (state_reg == ppgbd_pkg::ST_IDLE);
    assign cfg_ready = (state_reg == ppgbd_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ppgbd_pkg::ST_IDLE;
            for (int c = 0; c < 2; c++)
                for (int k = 0; k < 5; k++)
                begin
                    xh_reg[c][k] <= '0;
                    yh_reg[c][k] <= '0;
                end
            prev_level_reg <= '0;
            count_reg      <= '0;
            last_beat_reg  <= '0;
            for (int k = 0; k < INTERVAL_COUNT; k++) ivs_reg[k] <= '0;
            widx_reg       <= '0;
            mode_reg       <= 1'b0;
            thr_reg        <= ppgbd_pkg::THRESHOLD_RESET;
            ovalid_reg     <= 1'b0;
            tap_reg        <= '0;
            sidx_reg       <= '0;
            dcnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ovalid_reg && out_ready) ovalid_reg <= 1'b0;
            case (state_reg)
                ppgbd_pkg::ST_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        if (cfg_index == ppgbd_pkg::REG_OUTPUT_MODE) mode_reg <= cfg_data[0];
                        else thr_reg <= signed'(cfg_data);
                    end
                    if (in_valid)
                    begin
                        chan_reg <= command;
                        samp_reg <= sample_in;
                    end
                end
                ppgbd_pkg::ST_SCALE:
                begin
                    xs_reg  <= 32'((mul_p + 64'sd32768) >>> 16);
                    tap_reg <= 3'd0;
                end
                ppgbd_pkg::ST_MAC:
                begin
                    acc_reg <= ((tap_reg == 3'd0) ? fir_term : acc_reg) + mul_p;
                    tap_reg <= tap_reg + 3'd1;
                end
                ppgbd_pkg::ST_ROUND:
                begin
                    neg_reg <= yneg;
                    for (int k = 0; k < 4; k++)
                    begin
                        xh_reg[chan_reg][k] <= xh_reg[chan_reg][k+1];
                        yh_reg[chan_reg][k] <= yh_reg[chan_reg][k+1];
                    end
                    xh_reg[chan_reg][4] <= xs_reg;
                    yh_reg[chan_reg][4] <= ysat;
                    if (!chan_reg) count_reg <= count_reg + 32'd1;
                end
                ppgbd_pkg::ST_BEAT:
                begin
                    beat_reg <= beat_now;
                    if (!chan_reg) prev_level_reg <= neg_reg;
                    if (beat_now)
                    begin
                        last_beat_reg     <= count_reg;
                        ivs_reg[widx_reg] <= iv_sat;
                        widx_reg <= (32'(widx_reg) == INTERVAL_COUNT - 1) ? '0 : widx_reg + 1'b1;
                    end
                    sidx_reg <= '0;
                    sum_reg  <= '0;
                end
                ppgbd_pkg::ST_SUM:
                begin
                    sum_reg  <= sum_reg + SUM_W'(ivs_reg[sidx_reg]);
                    sidx_reg <= sidx_reg + 1'b1;
                    quo_reg  <= DIV_W'(DIV_N);
                    rem_reg  <= '0;
                    dcnt_reg <= '0;
                end
                ppgbd_pkg::ST_DIV:
                begin
                    // Restoring division, one quotient bit per cycle.
                    if (!rem_try[SUM_W])
                    begin
                        rem_reg <= rem_try;
                        quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[SUM_W-1:0], quo_reg[DIV_W-1]};
                        quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + 1'b1;
                end
                ppgbd_pkg::ST_OUT:
                begin
                    if (!ovalid_reg)
                    begin
                        ovalid_reg <= 1'b1;
                        ochan_reg  <= chan_reg;
                        oval_reg   <= mode_reg ? xs_reg : neg_reg;
                        obeat_reg  <= beat_reg;
                        osum_reg   <= (32'(sum_reg) > 32'(ppgbd_pkg::FIELD19_MAX))
                                      ? ppgbd_pkg::FIELD19_MAX : 19'(sum_reg);
                        orate_reg  <= (sum_reg == '0) ? 19'd0 :
                                      (32'(quo_reg) > 32'(ppgbd_pkg::FIELD19_MAX))
                                      ? ppgbd_pkg::FIELD19_MAX : 19'(quo_reg);
                    end
                end
                default: ;
            endcase
        end
    end

    assign out_valid       = ovalid_reg;
    assign channel_out     = ochan_reg;
    assign value_out       = oval_reg;
    assign beat_flag       = obeat_reg;
    assign interval_sum    = osum_reg;
    assign rate_tenths_bpm = orate_reg;

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_ir_nobeat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && channel_out |-> !beat_flag)
        else $error("beat on infrared");
    a_rate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && interval_sum == 19'd0 |-> rate_tenths_bpm == 19'd0)
        else $error("rate with zero sum");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted twice");
`endif

endmodule
